// ----- hdl/ymr_pkg.sv -----
// ----------------------------------------------------------------------------
// ymr_pkg
// Types and constants shared by the YMODEM packet receiver modules.
// ----------------------------------------------------------------------------
package ymr_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_BYTE        = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT     = 2'd1;
    localparam logic [1:0] REQ_SESSION_END = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_GOOD   = 3'd1;
    localparam logic [2:0] KIND_EOT    = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_ABORT  = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // control bytes
    localparam logic [7:0] CH_SOH      = 8'h01;
    localparam logic [7:0] CH_STX      = 8'h02;
    localparam logic [7:0] CH_EOT      = 8'h04;
    localparam logic [7:0] CH_CAN      = 8'h18;
    localparam logic [7:0] CH_ABORT_UC = 8'h41;
    localparam logic [7:0] CH_ABORT_LC = 8'h61;
    localparam logic [7:0] CH_IAC      = 8'hFF;
    localparam logic [7:0] CH_DO       = 8'hFD;
    localparam logic [7:0] CH_WILL     = 8'hFB;
    localparam logic [7:0] CH_BINARY   = 8'h00;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [10:0] SHORT_SIZE = 11'd128;
    localparam logic [10:0] LONG_SIZE  = 11'd1024;
    localparam logic [10:0] NEGO_LEN   = 11'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CANWAIT = 3'd1,
        PH_NEGO    = 3'd2,
        PH_SEQ     = 3'd3,
        PH_SEQC    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_TRAIL1  = 3'd6,
        PH_TRAIL2  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [9:0] byte_index;
        logic       long_packet;
        logic [7:0] block_number;
    } out_t;

    // telnet binary negotiation: IAC DO BINARY IAC WILL BINARY
    function automatic logic [7:0] nego_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = CH_IAC;
            3'd1:    val = CH_DO;
            3'd2:    val = CH_BINARY;
            3'd3:    val = CH_IAC;
            3'd4:    val = CH_WILL;
            3'd5:    val = CH_BINARY;
            default: val = CH_BINARY;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/ymr_crc.sv -----
// ----------------------------------------------------------------------------
// ymr_crc
// CRC-16/XMODEM update by one byte, msb first.
// ----------------------------------------------------------------------------
module ymr_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ ymr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ----- hdl/ymodem_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// ymodem_packet_receiver
// Deframes YMODEM packets from a byte stream with CRC16 or sum checking.
// ----------------------------------------------------------------------------
// Usage:
//   s_data carries one request per beat: a received byte, a receive timeout
//   or a session end. m_data carries at most one result per request: a
//   payload byte with its index, a packet verdict with the block number,
//   EOT, sender cancel, user abort or error.
//   cfg_wr_en/cfg_wr_data write use_crc (1 = two-byte CRC16 trailer,
//   0 = one-byte sum); write it only while the block is idle.
//   Each request is handled directly: the state update and the result
//   are computed from the request beat and land in the state registers and
//   the result register at the accepting edge, so a result shows on m_data
//   in the cycle after its request. One request is taken every cycle while
//   s_ready is high; the rate is set by the single result register.
//   When m_ready is low and a result is waiting, s_ready drops until the
//   result is taken; requests that give no result still need a free slot.
//   Reset returns to idle, clears telnet mode and use_crc, drops any result.
// ----------------------------------------------------------------------------
module ymodem_packet_receiver (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  ymr_pkg::in_t      s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ymr_pkg::out_t     m_data
);

    ymr_pkg::phase_t phase_reg, phase_next;
    logic [10:0] count_reg, count_next;
    logic        long_reg, long_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  seqc_reg, seqc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic        prev_ff_reg, prev_ff_next;
    logic        telnet_reg, telnet_next;
    logic        match_reg, match_next;
    logic        use_crc_reg;

    logic          out_valid_reg;
    ymr_pkg::out_t out_reg;
    logic          res_valid;
    ymr_pkg::out_t res;

    logic        s_accept;
    logic [7:0]  b;
    logic        is_ff;
    logic        in_body;
    logic        ff_drop;
    logic [10:0] count_inc;
    logic        nego_done;
    logic        nego_hit;
    logic        pay_last;
    logic [15:0] crc_upd;
    logic        seq_ok;
    logic        sum_ok;
    logic        crc_ok;

    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign b         = s_data.rx_byte;
    assign is_ff     = (b == ymr_pkg::CH_IAC);
    assign in_body   = (phase_reg == ymr_pkg::PH_SEQ) || (phase_reg == ymr_pkg::PH_SEQC)
                    || (phase_reg == ymr_pkg::PH_PAYLOAD) || (phase_reg == ymr_pkg::PH_TRAIL1)
                    || (phase_reg == ymr_pkg::PH_TRAIL2);
    // second ff of a doubled pair inside a packet is swallowed in telnet mode
    assign ff_drop   = telnet_reg && prev_ff_reg && is_ff;
    assign count_inc = count_reg + 11'd1;
    assign nego_done = (count_inc >= ymr_pkg::NEGO_LEN);
    assign nego_hit  = (b == ymr_pkg::nego_byte(count_reg[2:0]));
    assign pay_last  = (count_inc >= (long_reg ? ymr_pkg::LONG_SIZE : ymr_pkg::SHORT_SIZE));
    assign seq_ok    = (seq_reg == ~seqc_reg);
    assign sum_ok    = (sum_reg == b);
    assign crc_ok    = (crc_reg == {hold_reg, b});

    ymr_crc u_crc (
        .crc_in  (crc_reg),
        .data_in (b),
        .crc_out (crc_upd)
    );

    // next state
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        long_next    = long_reg;
        seq_next     = seq_reg;
        seqc_next    = seqc_reg;
        crc_next     = crc_reg;
        sum_next     = sum_reg;
        hold_next    = hold_reg;
        prev_ff_next = prev_ff_reg;
        telnet_next  = telnet_reg;
        match_next   = match_reg;
        if (s_accept) begin
            unique case (s_data.req_type)
                ymr_pkg::REQ_SESSION_END: begin
                    telnet_next  = 1'b0;
                    prev_ff_next = 1'b0;
                    phase_next   = ymr_pkg::PH_IDLE;
                end
                ymr_pkg::REQ_TIMEOUT: begin
                    phase_next = ymr_pkg::PH_IDLE;
                end
                ymr_pkg::REQ_BYTE: begin
                    if (in_body && telnet_reg) begin
                        prev_ff_next = ff_drop ? 1'b0 : is_ff;
                    end
                    unique case (phase_reg)
                        ymr_pkg::PH_IDLE: begin
                            if (b == ymr_pkg::CH_SOH || b == ymr_pkg::CH_STX) begin
                                long_next    = (b == ymr_pkg::CH_STX);
                                count_next   = '0;
                                crc_next     = '0;
                                sum_next     = '0;
                                prev_ff_next = 1'b0;
                                phase_next   = ymr_pkg::PH_SEQ;
                            end else if (b == ymr_pkg::CH_CAN) begin
                                phase_next = ymr_pkg::PH_CANWAIT;
                            end else if (is_ff) begin
                                count_next = 11'd1;
                                match_next = 1'b1;
                                phase_next = ymr_pkg::PH_NEGO;
                            end
                        end
                        ymr_pkg::PH_CANWAIT: begin
                            phase_next = ymr_pkg::PH_IDLE;
                        end
                        ymr_pkg::PH_NEGO: begin
                            if (nego_done) begin
                                if (match_reg && nego_hit) begin
                                    telnet_next = 1'b1;
                                end
                                match_next = 1'b1;
                                count_next = '0;
                                phase_next = ymr_pkg::PH_IDLE;
                            end else begin
                                match_next = match_reg && nego_hit;
                                count_next = count_inc;
                            end
                        end
                        ymr_pkg::PH_SEQ: begin
                            if (!ff_drop) begin
                                seq_next   = b;
                                phase_next = ymr_pkg::PH_SEQC;
                            end
                        end
                        ymr_pkg::PH_SEQC: begin
                            if (!ff_drop) begin
                                seqc_next  = b;
                                phase_next = ymr_pkg::PH_PAYLOAD;
                            end
                        end
                        ymr_pkg::PH_PAYLOAD: begin
                            if (!ff_drop) begin
                                crc_next   = crc_upd;
                                sum_next   = sum_reg + b;
                                count_next = count_inc;
                                if (pay_last) begin
                                    phase_next = ymr_pkg::PH_TRAIL1;
                                end
                            end
                        end
                        ymr_pkg::PH_TRAIL1: begin
                            if (!ff_drop) begin
                                if (use_crc_reg) begin
                                    hold_next  = b;
                                    phase_next = ymr_pkg::PH_TRAIL2;
                                end else begin
                                    phase_next = ymr_pkg::PH_IDLE;
                                end
                            end
                        end
                        ymr_pkg::PH_TRAIL2: begin
                            if (!ff_drop) begin
                                phase_next = ymr_pkg::PH_IDLE;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // result for the current request
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (s_data.req_type)
            ymr_pkg::REQ_TIMEOUT: begin
                res_valid = 1'b1;
                res.kind  = ymr_pkg::KIND_ERROR;
            end
            ymr_pkg::REQ_BYTE: begin
                unique case (phase_reg)
                    ymr_pkg::PH_IDLE: begin
                        if (b == ymr_pkg::CH_EOT) begin
                            res_valid = 1'b1;
                            res.kind  = ymr_pkg::KIND_EOT;
                        end else if (b == ymr_pkg::CH_ABORT_UC || b == ymr_pkg::CH_ABORT_LC) begin
                            res_valid = 1'b1;
                            res.kind  = ymr_pkg::KIND_ABORT;
                        end else if (!(b == ymr_pkg::CH_SOH || b == ymr_pkg::CH_STX
                                       || b == ymr_pkg::CH_CAN || is_ff)) begin
                            res_valid = 1'b1;
                            res.kind  = ymr_pkg::KIND_ERROR;
                        end
                    end
                    ymr_pkg::PH_CANWAIT: begin
                        res_valid = 1'b1;
                        res.kind  = (b == ymr_pkg::CH_CAN) ? ymr_pkg::KIND_CANCEL
                                                           : ymr_pkg::KIND_ERROR;
                    end
                    ymr_pkg::PH_NEGO: begin
                        if (nego_done) begin
                            res_valid = 1'b1;
                            res.kind  = ymr_pkg::KIND_ERROR;
                        end
                    end
                    ymr_pkg::PH_SEQ, ymr_pkg::PH_SEQC: begin
                    end
                    ymr_pkg::PH_PAYLOAD: begin
                        if (!ff_drop) begin
                            res_valid       = 1'b1;
                            res.kind        = ymr_pkg::KIND_DATA;
                            res.data_byte   = b;
                            res.byte_index  = count_reg[9:0];
                            res.long_packet = long_reg;
                        end
                    end
                    ymr_pkg::PH_TRAIL1, ymr_pkg::PH_TRAIL2: begin
                        // verdict on the last trailer byte
                        if (!ff_drop && (phase_reg == ymr_pkg::PH_TRAIL2 || !use_crc_reg)) begin
                            res_valid = 1'b1;
                            if (seq_ok
                                    && ((phase_reg == ymr_pkg::PH_TRAIL2) ? crc_ok : sum_ok)) begin
                                res.kind         = ymr_pkg::KIND_GOOD;
                                res.long_packet  = long_reg;
                                res.block_number = seq_reg;
                            end else begin
                                res.kind = ymr_pkg::KIND_ERROR;
                            end
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ymr_pkg::PH_IDLE;
            count_reg     <= '0;
            long_reg      <= 1'b0;
            seq_reg       <= '0;
            seqc_reg      <= '0;
            crc_reg       <= '0;
            sum_reg       <= '0;
            hold_reg      <= '0;
            prev_ff_reg   <= 1'b0;
            telnet_reg    <= 1'b0;
            match_reg     <= 1'b1;
            use_crc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            long_reg    <= long_next;
            seq_reg     <= seq_next;
            seqc_reg    <= seqc_next;
            crc_reg     <= crc_next;
            sum_reg     <= sum_next;
            hold_reg    <= hold_next;
            prev_ff_reg <= prev_ff_next;
            telnet_reg  <= telnet_next;
            match_reg   <= match_next;
            if (cfg_wr_en) begin
                use_crc_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a result beat
    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            out_reg <= res;
        end
    end

endmodule
